/* hw/rtl/fss_pkg.sv */
// types, codes and reset constants shared by the fire suppression sequencer
package fss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    SEQ_NORMAL = 3'd0,
    SEQ_FIRE   = 3'd1,
    SEQ_EXPIRY = 3'd2,
    SEQ_PIN    = 3'd3,
    SEQ_AIM    = 3'd4,
    SEQ_ARM    = 3'd5,
    SEQ_LEVER  = 3'd6
  } seq_state_t;

  typedef enum logic [1:0] {
    SIMPLE_NORMAL = 2'd0,
    SIMPLE_FIRE   = 2'd1,
    SIMPLE_EXPIRY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LEVER_FWD   = 2'd0,
    LEVER_HOLD  = 2'd1,
    LEVER_REV   = 2'd2,
    LEVER_PAUSE = 2'd3
  } lever_phase_t;

  localparam logic       OP_TICK  = 1'b0;
  localparam logic       OP_FORCE = 1'b1;
  localparam logic [2:0] FORCE_NONE = 3'd7;

  localparam logic [1:0] MOTOR_B_STOP = 2'd0;
  localparam logic [1:0] MOTOR_B_FWD  = 2'd1;
  localparam logic [1:0] MOTOR_B_REV  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAS_THR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVER_HOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVER_PAUSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_TARGET  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_SPEED = 3'd7;

  localparam logic        [11:0] RST_GAS_THR     = 12'd2000;
  localparam logic signed [11:0] RST_TEMP_THR    = 12'sd500;
  localparam logic        [15:0] RST_ALARM_HOLD  = 16'd600;
  localparam logic        [15:0] RST_STEP        = 16'd100;
  localparam logic        [15:0] RST_LEVER_HOLD  = 16'd200;
  localparam logic        [15:0] RST_LEVER_PAUSE = 16'd10;

  typedef struct packed {
    logic              opcode;
    logic [11:0]       gas_mv;
    logic signed [11:0] temperature_dc;
    logic              emergency_pressed;
    logic              life_expired;
    logic [7:0]        aim_deg;
    logic [2:0]        forced_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] seq_state;
    logic [1:0] status;
    logic       alarm_on;
    logic       motor_a_cmd;
    logic [1:0] motor_b_cmd;
    logic       floor_cmd_valid;
    logic [7:0] floor_angle_deg;
    logic       arm_cmd_valid;
    logic       state_changed;
  } out_item_t;

  typedef struct packed {
    logic [11:0]        gas_thr;
    logic signed [11:0] temp_thr;
    logic [15:0]        alarm_hold;
    logic [15:0]        step;
    logic [15:0]        lever_hold;
    logic [15:0]        lever_pause;
  } cfg_t;

  typedef struct packed {
    seq_state_t    seq;
    status_t       simple;
    logic [15:0]   phase_ticks;
    lever_phase_t  lever;
    logic [7:0]    floor_angle;
  } state_t;

endpackage

/* hw/rtl/fss_channels.sv */
// valid/ready channel interfaces for tick items and results
interface fss_in_if;
  import fss_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fss_out_if;
  import fss_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fss_core.sv */
// next-state and result logic for one tick or force transaction
module fss_core (
  input  fss_pkg::state_t    st,
  input  fss_pkg::in_item_t  item,
  input  fss_pkg::cfg_t      cfg,
  output fss_pkg::state_t    st_nxt,
  output fss_pkg::out_item_t res
);
  import fss_pkg::*;

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic        done;
  logic        floor_v;
  logic        arm_v;
  logic        changed;
  seq_state_t  forced_seq;

  assign tick_inc   = st.phase_ticks + 16'd1;
  assign done       = tick_inc >= limit;
  assign forced_seq = seq_state_t'(item.forced_state);

  always_comb begin
    case (st.seq)
      SEQ_FIRE: limit = cfg.alarm_hold;
      SEQ_LEVER: begin
        case (st.lever)
          LEVER_HOLD:  limit = cfg.lever_hold;
          LEVER_PAUSE: limit = cfg.lever_pause;
          default:     limit = cfg.step;
        endcase
      end
      default: limit = cfg.step;
    endcase
  end

  always_comb begin
    st_nxt  = st;
    floor_v = 1'b0;
    arm_v   = 1'b0;
    changed = 1'b0;
    if (item.opcode == OP_FORCE) begin
      if (item.forced_state != FORCE_NONE) begin
        st_nxt.seq         = forced_seq;
        st_nxt.phase_ticks = '0;
        st_nxt.lever       = LEVER_FWD;
        if (forced_seq == SEQ_AIM) begin
          st_nxt.floor_angle = item.aim_deg;
          floor_v            = 1'b1;
        end
        if (forced_seq == SEQ_ARM) begin
          arm_v = 1'b1;
        end
      end
      changed = 1'b1;
    end else begin
      if (st.seq != SEQ_NORMAL && item.emergency_pressed) begin
        st_nxt.seq         = SEQ_NORMAL;
        st_nxt.simple      = SIMPLE_NORMAL;
        st_nxt.phase_ticks = '0;
        st_nxt.lever       = LEVER_FWD;
      end else begin
        case (st.seq)
          SEQ_NORMAL: begin
            if (item.life_expired) begin
              st_nxt.seq    = SEQ_EXPIRY;
              st_nxt.simple = SIMPLE_EXPIRY;
            end else if (item.gas_mv > cfg.gas_thr ||
                         item.temperature_dc > cfg.temp_thr) begin
              st_nxt.seq    = SEQ_FIRE;
              st_nxt.simple = SIMPLE_FIRE;
            end else begin
              st_nxt.simple = SIMPLE_NORMAL;
            end
            st_nxt.phase_ticks = '0;
          end
          SEQ_FIRE: begin
            st_nxt.phase_ticks = done ? 16'd0 : tick_inc;
            if (done) begin
              st_nxt.seq = SEQ_PIN;
            end
          end
          SEQ_EXPIRY: begin
            st_nxt.simple      = SIMPLE_EXPIRY;
            st_nxt.phase_ticks = '0;
          end
          SEQ_PIN: begin
            st_nxt.phase_ticks = done ? 16'd0 : tick_inc;
            if (done) begin
              st_nxt.seq         = SEQ_AIM;
              st_nxt.floor_angle = item.aim_deg;
              floor_v            = 1'b1;
            end
          end
          SEQ_AIM: begin
            st_nxt.phase_ticks = done ? 16'd0 : tick_inc;
            if (done) begin
              st_nxt.seq = SEQ_ARM;
              arm_v      = 1'b1;
            end
          end
          SEQ_ARM: begin
            st_nxt.phase_ticks = done ? 16'd0 : tick_inc;
            if (done) begin
              st_nxt.seq   = SEQ_LEVER;
              st_nxt.lever = LEVER_FWD;
            end
          end
          SEQ_LEVER: begin
            st_nxt.phase_ticks = done ? 16'd0 : tick_inc;
            if (done) begin
              st_nxt.lever = lever_phase_t'(st.lever + 2'd1);
            end
          end
          default: begin
            st_nxt = st;
          end
        endcase
      end
      changed = (st_nxt.seq != st.seq) || (st_nxt.simple != st.simple);
    end
  end

  always_comb begin
    res.seq_state       = st_nxt.seq;
    res.status          = st_nxt.simple;
    res.alarm_on        = st_nxt.seq != SEQ_NORMAL;
    res.motor_a_cmd     = st_nxt.seq == SEQ_PIN;
    res.motor_b_cmd     = MOTOR_B_STOP;
    if (st_nxt.seq == SEQ_LEVER) begin
      if (st_nxt.lever == LEVER_FWD) begin
        res.motor_b_cmd = MOTOR_B_FWD;
      end else if (st_nxt.lever == LEVER_REV) begin
        res.motor_b_cmd = MOTOR_B_REV;
      end
    end
    res.floor_cmd_valid = floor_v;
    res.floor_angle_deg = st_nxt.floor_angle;
    res.arm_cmd_valid   = arm_v;
    res.state_changed   = changed;
  end

endmodule

/* hw/rtl/fire_suppression_sequencer.sv */
// fire suppression sequencer top level
// One transaction is one 50 ms tick carrying sensor readings, or a force
// command. The block takes one transaction every clock cycle while the
// output is not stalled; an accepted transaction sits in the input register
// while the next state and result are formed, and the result register loads
// the result once it is empty or being drained. The sequence state updates at
// the same edge the result register loads, so back-to-back ticks see each
// other's effect. Output backpressure stalls the input only once both
// registers are full.
// Configuration writes take effect on the next edge and must be made with
// no transaction in flight. Motor speed and arm target are accepted but do
// not affect any result field.
module fire_suppression_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  fss_in_if.sink                         in_ch,
  fss_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fss_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  state_t    st_r;
  state_t    st_nxt;
  out_item_t res;
  cfg_t      cfg_r;
  logic      adv;
  logic      s1_valid_nxt;
  logic      out_valid_nxt;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign s1_valid_nxt = in_ch.valid ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  fss_core u_core (
    .st     (st_r),
    .item   (s1_data_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.seq         <= SEQ_NORMAL;
      st_r.simple      <= SIMPLE_NORMAL;
      st_r.phase_ticks <= '0;
      st_r.lever       <= LEVER_FWD;
      st_r.floor_angle <= '0;
    end else begin
      s1_valid_r  <= in_ch.ready ? s1_valid_nxt : s1_valid_r;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gas_thr     <= RST_GAS_THR;
      cfg_r.temp_thr    <= RST_TEMP_THR;
      cfg_r.alarm_hold  <= RST_ALARM_HOLD;
      cfg_r.step        <= RST_STEP;
      cfg_r.lever_hold  <= RST_LEVER_HOLD;
      cfg_r.lever_pause <= RST_LEVER_PAUSE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAS_THR:     cfg_r.gas_thr     <= cfg_wdata[11:0];
        CFG_TEMP_THR:    cfg_r.temp_thr    <= $signed(cfg_wdata[11:0]);
        CFG_ALARM_HOLD:  cfg_r.alarm_hold  <= cfg_wdata;
        CFG_STEP:        cfg_r.step        <= cfg_wdata;
        CFG_LEVER_HOLD:  cfg_r.lever_hold  <= cfg_wdata;
        CFG_LEVER_PAUSE: cfg_r.lever_pause <= cfg_wdata;
        CFG_ARM_TARGET:  cfg_r <= cfg_r;
        CFG_MOTOR_SPEED: cfg_r <= cfg_r;
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

endmodule

/* hw/rtl/fss_checker.sv */
// port-level assertions for the fire suppression sequencer, bound to the top
module fss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fss_pkg::out_item_t out_data
);
  import fss_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a drained output slot always frees the input side
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled although output drained");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.alarm_on == (out_data.seq_state != SEQ_NORMAL))
    else $error("alarm does not follow state");

  a_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.motor_a_cmd || out_data.floor_cmd_valid ||
    out_data.arm_cmd_valid) |-> $countones({out_data.motor_a_cmd,
    out_data.floor_cmd_valid, out_data.arm_cmd_valid}) == 1 &&
    (!out_data.motor_a_cmd || out_data.seq_state == SEQ_PIN) &&
    (!out_data.floor_cmd_valid || out_data.seq_state == SEQ_AIM) &&
    (!out_data.arm_cmd_valid || out_data.seq_state == SEQ_ARM))
    else $error("actuator command outside its state");

endmodule

bind fire_suppression_sequencer fss_checker u_fss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* bench/tb.sv */
// self-checking testbench for the fire suppression sequencer: directed table, then random ticks and forces
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fss_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 90;
  localparam logic [7:0]  RST_ARM_TARGET  = 8'd60;
  localparam logic [9:0]  RST_MOTOR_SPEED = 10'd1000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t outp;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fss_in_if  in_ch ();
  fss_out_if out_ch ();

  fire_suppression_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the sequencer state and registers
  seq_state_t         p_seq;
  status_t            p_simple;
  logic [15:0]        p_ticks;
  lever_phase_t       p_lever;
  logic [7:0]         p_floor;
  logic [11:0]        c_gas;
  logic signed [11:0] c_temp;
  logic [15:0]        c_alarm;
  logic [15:0]        c_step;
  logic [15:0]        c_hold;
  logic [15:0]        c_pause;
  logic [7:0]         c_arm;
  logic [9:0]         c_speed;

  out_item_t   expected_outputs [$];
  dir_row_t    typed_outputs [$];
  dir_row_t    dir_rows [$];
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned stall_mode;
  bit          hold_off_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    p_seq    = SEQ_NORMAL;
    p_simple = SIMPLE_NORMAL;
    p_ticks  = '0;
    p_lever  = LEVER_FWD;
    p_floor  = '0;
    c_gas    = RST_GAS_THR;
    c_temp   = RST_TEMP_THR;
    c_alarm  = RST_ALARM_HOLD;
    c_step   = RST_STEP;
    c_hold   = RST_LEVER_HOLD;
    c_pause  = RST_LEVER_PAUSE;
    c_arm    = RST_ARM_TARGET;
    c_speed  = RST_MOTOR_SPEED;
  endfunction

  function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_GAS_THR:     c_gas   = v[11:0];
      CFG_TEMP_THR:    c_temp  = v[11:0];
      CFG_ALARM_HOLD:  c_alarm = v;
      CFG_STEP:        c_step  = v;
      CFG_LEVER_HOLD:  c_hold  = v;
      CFG_LEVER_PAUSE: c_pause = v;
      CFG_ARM_TARGET:  c_arm   = v[7:0];
      CFG_MOTOR_SPEED: c_speed = v[9:0];
      default: ;
    endcase
  endfunction

  function automatic bit phase_elapsed(logic [15:0] lim);
    p_ticks = p_ticks + 16'd1;
    if (p_ticks >= lim) begin
      p_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t sequencer_advance(in_item_t it);
    out_item_t     r;
    seq_state_t    old_seq;
    status_t       old_simple;
    logic          fv;
    logic          av;
    logic          chg;
    logic [15:0]   lim;
    old_seq    = p_seq;
    old_simple = p_simple;
    fv = 1'b0;
    av = 1'b0;
    if (it.opcode == OP_FORCE) begin
      if (it.forced_state != FORCE_NONE) begin
        p_seq   = seq_state_t'(it.forced_state);
        p_ticks = '0;
        p_lever = LEVER_FWD;
        if (p_seq == SEQ_AIM) begin
          p_floor = it.aim_deg;
          fv = 1'b1;
        end
        if (p_seq == SEQ_ARM) av = 1'b1;
      end
      chg = 1'b1;
    end else begin
      if (p_seq != SEQ_NORMAL && it.emergency_pressed) begin
        p_seq    = SEQ_NORMAL;
        p_simple = SIMPLE_NORMAL;
        p_ticks  = '0;
        p_lever  = LEVER_FWD;
      end else begin
        case (p_seq)
          SEQ_NORMAL: begin
            if (it.life_expired) begin
              p_seq    = SEQ_EXPIRY;
              p_simple = SIMPLE_EXPIRY;
            end else if (it.gas_mv > c_gas || $signed(it.temperature_dc) > c_temp) begin
              p_seq    = SEQ_FIRE;
              p_simple = SIMPLE_FIRE;
            end else begin
              p_simple = SIMPLE_NORMAL;
            end
            p_ticks = '0;
          end
          SEQ_FIRE: begin
            if (phase_elapsed(c_alarm)) p_seq = SEQ_PIN;
          end
          SEQ_EXPIRY: begin
            p_simple = SIMPLE_EXPIRY;
            p_ticks  = '0;
          end
          SEQ_PIN: begin
            if (phase_elapsed(c_step)) begin
              p_seq   = SEQ_AIM;
              p_floor = it.aim_deg;
              fv = 1'b1;
            end
          end
          SEQ_AIM: begin
            if (phase_elapsed(c_step)) begin
              p_seq = SEQ_ARM;
              av = 1'b1;
            end
          end
          SEQ_ARM: begin
            if (phase_elapsed(c_step)) begin
              p_seq   = SEQ_LEVER;
              p_lever = LEVER_FWD;
            end
          end
          default: begin
            case (p_lever)
              LEVER_FWD:  lim = c_step;
              LEVER_HOLD: lim = c_hold;
              LEVER_REV:  lim = c_step;
              default:    lim = c_pause;
            endcase
            if (phase_elapsed(lim)) p_lever = lever_phase_t'(2'(p_lever + 2'd1));
          end
        endcase
      end
      chg = (p_seq != old_seq) || (p_simple != old_simple);
    end
    r.seq_state       = p_seq;
    r.status          = p_simple;
    r.alarm_on        = (p_seq != SEQ_NORMAL);
    r.motor_a_cmd     = (p_seq == SEQ_PIN);
    if (p_seq != SEQ_LEVER)       r.motor_b_cmd = MOTOR_B_STOP;
    else if (p_lever == LEVER_FWD) r.motor_b_cmd = MOTOR_B_FWD;
    else if (p_lever == LEVER_REV) r.motor_b_cmd = MOTOR_B_REV;
    else                          r.motor_b_cmd = MOTOR_B_STOP;
    r.floor_cmd_valid = fv;
    r.floor_angle_deg = p_floor;
    r.arm_cmd_valid   = av;
    r.state_changed   = chg;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void compare_outputs(out_item_t e, out_item_t a);
    check_field("seq_state", 8'(e.seq_state), 8'(a.seq_state));
    check_field("status", 8'(e.status), 8'(a.status));
    check_field("alarm_on", 8'(e.alarm_on), 8'(a.alarm_on));
    check_field("motor_a_cmd", 8'(e.motor_a_cmd), 8'(a.motor_a_cmd));
    check_field("motor_b_cmd", 8'(e.motor_b_cmd), 8'(a.motor_b_cmd));
    check_field("floor_cmd_valid", 8'(e.floor_cmd_valid), 8'(a.floor_cmd_valid));
    check_field("floor_angle_deg", e.floor_angle_deg, a.floor_angle_deg);
    check_field("arm_cmd_valid", 8'(e.arm_cmd_valid), 8'(a.arm_cmd_valid));
    check_field("state_changed", 8'(e.state_changed), 8'(a.state_changed));
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t e;
    dir_row_t  pin;
    if (rst_n) begin
      if (cfg_we) cfg_apply(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        e = sequencer_advance(in_ch.data);
        if (typed_outputs.size() > 0) begin
          pin = typed_outputs.pop_front();
          if (pin.typed) e = pin.outp;
        end
        expected_outputs.push_back(e);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %p", $time, out_ch.data);
          errors++;
        end else begin
          compare_outputs(expected_outputs.pop_front(), out_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall pattern, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(4, 50);
        end
        stall_left--;
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) != 0);
          default: out_ch.ready <= ((stall_left % 4) != 0);
        endcase
      end
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic in_item_t tick_item(int gas, int temp, bit emerg, bit expiry, int aim);
    in_item_t it;
    it.opcode            = OP_TICK;
    it.gas_mv            = 12'(gas);
    it.temperature_dc    = 12'(temp);
    it.emergency_pressed = emerg;
    it.life_expired      = expiry;
    it.aim_deg           = 8'(aim);
    it.forced_state      = FORCE_NONE;
    return it;
  endfunction

  // sensor fields carry noise that a force must ignore
  function automatic in_item_t force_item(logic [2:0] st, int aim);
    in_item_t it;
    it = tick_item(4095, 1250, 1'b1, 1'b1, aim);
    it.opcode       = OP_FORCE;
    it.forced_state = st;
    return it;
  endfunction

  function automatic out_item_t outcome(seq_state_t s, status_t m, logic [1:0] mb,
                                        bit fv, int fa, bit av, bit chg);
    out_item_t r;
    r.seq_state       = s;
    r.status          = m;
    r.alarm_on        = (s != SEQ_NORMAL);
    r.motor_a_cmd     = (s == SEQ_PIN);
    r.motor_b_cmd     = mb;
    r.floor_cmd_valid = fv;
    r.floor_angle_deg = 8'(fa);
    r.arm_cmd_valid   = av;
    r.state_changed   = chg;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t o);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.outp  = o;
    dir_rows.push_back(row);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       v;
    it.opcode            = ($urandom_range(0, 99) < 5) ? OP_FORCE : OP_TICK;
    it.forced_state      = 3'($urandom_range(0, 7));
    it.emergency_pressed = ($urandom_range(0, 99) < 3);
    it.life_expired      = ($urandom_range(0, 99) < 3);
    if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 4095);
    else v = clamp(int'(c_gas) + int'($urandom_range(0, 6)) - 3, 0, 4095);
    it.gas_mv = 12'(v);
    if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 1650)) - 400;
    else v = clamp(int'(c_temp) + int'($urandom_range(0, 6)) - 3, -400, 1250);
    it.temperature_dc = 12'(v);
    it.aim_deg        = 8'($urandom_range(0, 180));
    return it;
  endfunction

  task automatic offer(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(v);
    @(posedge clk);
  endtask

  task automatic load_cfg(int gas, int temp, int alarm, int step, int hold, int pause,
                          int arm, int speed);
    write_reg(CFG_GAS_THR, gas);
    write_reg(CFG_TEMP_THR, temp);
    write_reg(CFG_ALARM_HOLD, alarm);
    write_reg(CFG_STEP, step);
    write_reg(CFG_LEVER_HOLD, hold);
    write_reg(CFG_LEVER_PAUSE, pause);
    write_reg(CFG_ARM_TARGET, arm);
    write_reg(CFG_MOTOR_SPEED, speed);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_random_cfg(int tmax);
    load_cfg($urandom_range(0, 4095), int'($urandom_range(0, 1650)) - 400,
             $urandom_range(1, tmax), $urandom_range(1, tmax), $urandom_range(1, tmax),
             $urandom_range(1, tmax), $urandom_range(0, 180), $urandom_range(0, 1023));
  endtask

  task automatic run_phase(int n, bit pressure);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) begin
        hold_off_req = 1'b1;
        burst_left   = 60;
      end
      offer(rand_item());
    end
  endtask

  task automatic build_table();
    add_row(tick_item(0, -400, 0, 0, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 0, 0, 0));
    // equal to threshold does not trip
    add_row(tick_item(2000, 500, 0, 0, 90), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 0, 0, 0));
    add_row(tick_item(4095, -400, 0, 0, 0), 1,
            outcome(SEQ_FIRE, SIMPLE_FIRE, MOTOR_B_STOP, 0, 0, 0, 1));
    add_row(tick_item(0, 0, 1, 0, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 0, 0, 1));
    // button ignored in normal
    add_row(tick_item(0, 1250, 1, 0, 0), 1,
            outcome(SEQ_FIRE, SIMPLE_FIRE, MOTOR_B_STOP, 0, 0, 0, 1));
    add_row(tick_item(4095, 1250, 0, 1, 180), 1,
            outcome(SEQ_FIRE, SIMPLE_FIRE, MOTOR_B_STOP, 0, 0, 0, 0));
    add_row(force_item(SEQ_AIM, 180), 1,
            outcome(SEQ_AIM, SIMPLE_FIRE, MOTOR_B_STOP, 1, 180, 0, 1));
    add_row(force_item(FORCE_NONE, 0), 1,
            outcome(SEQ_AIM, SIMPLE_FIRE, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(force_item(SEQ_ARM, 0), 1,
            outcome(SEQ_ARM, SIMPLE_FIRE, MOTOR_B_STOP, 0, 180, 1, 1));
    add_row(force_item(SEQ_LEVER, 0), 1,
            outcome(SEQ_LEVER, SIMPLE_FIRE, MOTOR_B_FWD, 0, 180, 0, 1));
    add_row(tick_item(0, 0, 0, 0, 0), 0, '0);
    add_row(force_item(SEQ_PIN, 0), 1,
            outcome(SEQ_PIN, SIMPLE_FIRE, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(tick_item(0, 0, 1, 0, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 180, 0, 1));
    // expiry wins over a fire reading
    add_row(tick_item(4095, 1250, 0, 1, 0), 1,
            outcome(SEQ_EXPIRY, SIMPLE_EXPIRY, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(tick_item(0, -400, 0, 0, 0), 1,
            outcome(SEQ_EXPIRY, SIMPLE_EXPIRY, MOTOR_B_STOP, 0, 180, 0, 0));
    add_row(tick_item(0, 0, 1, 1, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 180, 0, 1));
    // force leaves simple state alone
    add_row(force_item(SEQ_EXPIRY, 0), 1,
            outcome(SEQ_EXPIRY, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(tick_item(0, 0, 0, 0, 0), 1,
            outcome(SEQ_EXPIRY, SIMPLE_EXPIRY, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(force_item(SEQ_NORMAL, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_EXPIRY, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(tick_item(0, 0, 0, 0, 0), 1,
            outcome(SEQ_NORMAL, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(force_item(SEQ_FIRE, 0), 1,
            outcome(SEQ_FIRE, SIMPLE_NORMAL, MOTOR_B_STOP, 0, 180, 0, 1));
    add_row(tick_item(4095, 1250, 0, 1, 100), 0, '0);
    add_row(force_item(SEQ_AIM, 0), 1,
            outcome(SEQ_AIM, SIMPLE_NORMAL, MOTOR_B_STOP, 1, 0, 0, 1));
    add_row(force_item(SEQ_NORMAL, 0), 0, '0);
    add_row(tick_item(2001, -400, 0, 0, 0), 0, '0);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_GAS_THR;
    cfg_wdata    <= '0;
    errors       = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    stall_left   = 0;
    stall_mode   = 0;
    hold_off_req = 1'b0;
    reset_model();
    build_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    foreach (dir_rows[i]) begin
      typed_outputs.push_back(dir_rows[i]);
      offer(dir_rows[i].item);
    end

    settle();
    load_random_cfg(8);
    run_phase(120, 1'b0);

    settle();
    load_cfg(0, -400, 1, 1, 1, 1, 0, 0);
    run_phase(110, 1'b0);

    settle();
    load_random_cfg(12);
    run_phase(130, 1'b1);

    settle();
    load_cfg(4095, 1250, 65535, 65535, 65535, 65535, 180, 1023);
    run_phase(40, 1'b0);

    settle();
    load_random_cfg(5);
    run_phase(130, 1'b0);

    settle();
    load_cfg($urandom_range(1500, 2500), -int'($urandom_range(0, 400)), $urandom_range(1, 6),
             $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
             $urandom_range(0, 180), $urandom_range(0, 1023));
    run_phase(100, 1'b0);

    settle();
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing", $time, errors,
               expected_outputs.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
